FILE: rtl/itsr_pkg.sv
// ----------------------------------------------------------------------------
// itsr_pkg
// Shared sizes, codes and types of the integer table search and remove block.
// ----------------------------------------------------------------------------
package itsr_pkg;

    // table geometry
    localparam int DEPTH = 256;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int POS_W = CNT_W + 1;

    // result field widths
    localparam int DATA_W = 32;
    localparam int KIND_W = 3;
    localparam int STAT_W = 2;
    localparam int LOC_W  = 9;
    localparam logic [LOC_W-1:0] LOC_NONE = '1;

    // operation codes
    typedef enum logic [KIND_W-1:0] {
        KIND_APPEND = 3'd0,
        KIND_ZERO   = 3'd1,
        KIND_FIND   = 3'd2,
        KIND_OFIND  = 3'd3,
        KIND_REMOVE = 3'd4,
        KIND_MINMAX = 3'd5
    } kind_t;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_EMPTY     = 2'd3
    } status_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_ZERO,
        S_SCAN,
        S_BIN_RD,
        S_BIN_CMP,
        S_DONE
    } state_t;

    // memory access request from the sequencer
    typedef struct packed {
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [DATA_W-1:0] wr_data;
    } mem_req_t;

    // compare unit flags
    typedef struct packed {
        logic eq;
        logic data_lt_key;
        logic data_lt_min;
        logic data_gt_max;
    } cmp_t;

endpackage

FILE: rtl/itsr_if.sv
// ----------------------------------------------------------------------------
// itsr_if
// Valid/ready channels carrying operation beats and result beats.
// ----------------------------------------------------------------------------
interface itsr_req_if
    import itsr_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface itsr_rsp_if
    import itsr_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic signed [LOC_W-1:0]  location;
    logic signed [DATA_W-1:0] min_value;
    logic signed [DATA_W-1:0] max_value;
    logic [LOC_W-1:0]         entry_count;

    modport source (output valid, output status, output location, output min_value,
                    output max_value, output entry_count, input ready);
    modport sink   (input valid, input status, input location, input min_value,
                    input max_value, input entry_count, output ready);
endinterface

FILE: rtl/itsr_store.sv
// ----------------------------------------------------------------------------
// itsr_store
// Entry memory: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module itsr_store
    import itsr_pkg::*;
(
    input  logic              clk,
    input  mem_req_t          req,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/itsr_cmp.sv
// ----------------------------------------------------------------------------
// itsr_cmp
// Shared compare unit: the entry just read against key, minimum and maximum.
// ----------------------------------------------------------------------------
module itsr_cmp
    import itsr_pkg::*;
(
    input  logic [DATA_W-1:0] data,
    input  logic [DATA_W-1:0] key,
    input  logic [DATA_W-1:0] min_val,
    input  logic [DATA_W-1:0] max_val,
    output cmp_t              flags
);

    // signed compares of the read entry
    always_comb
    begin
        flags.eq          = (data == key);
        flags.data_lt_key = ($signed(data) < $signed(key));
        flags.data_lt_min = ($signed(data) < $signed(min_val));
        flags.data_gt_max = ($signed(data) > $signed(max_val));
    end

endmodule

FILE: rtl/int_table_search_remove_core.sv
// ----------------------------------------------------------------------------
// int_table_search_remove_core
// Table of signed 32-bit entries with append, zero, find, ordered find,
// remove and min/max, run one operation at a time by a small sequencer.
// ----------------------------------------------------------------------------
// Usage: each beat on req carries kind and value; exactly one beat on rsp
// follows with status, location, min_value, max_value and entry_count.
// req.ready is high only while the sequencer is idle, so one operation is in
// the block at a time. With n live entries, linear find, remove and min/max
// scan the live entries, reading one entry per cycle through the memory
// read port, whose read data is registered; ordered find makes at most
// log2(n) + 1 probes, each a read and a compare. Remove compacts the table
// in the same single pass, writing kept entries back through the write
// port as it reads.
// The result sits in an output register; while rsp is stalled the next
// beat can still be accepted and worked, and its result waits until the
// register frees. Reset clears the live count and all control state; the
// entry memory has no reset and needs no clearing pass, since only entries
// that were appended are ever read.
// ----------------------------------------------------------------------------
module int_table_search_remove_core
    import itsr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    itsr_req_if.sink   req,
    itsr_rsp_if.source rsp
);

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic                     pv_reg, pv_next;
    logic                     skip_reg, skip_next;
    logic                     out_valid_reg, out_valid_next;

    logic [KIND_W-1:0]        kind_reg, kind_next;
    logic [DATA_W-1:0]        value_reg, value_next;
    logic [IDX_W-1:0]         p_idx_reg, p_idx_next;
    logic [IDX_W-1:0]         mid_reg, mid_next;
    logic signed [POS_W-1:0]  left_reg, left_next;
    logic signed [POS_W-1:0]  right_reg, right_next;
    status_t                  status_reg, status_next;
    logic [LOC_W-1:0]         loc_reg, loc_next;
    logic [DATA_W-1:0]        min_reg, min_next;
    logic [DATA_W-1:0]        max_reg, max_next;

    logic [STAT_W-1:0]        o_status_reg, o_status_next;
    logic [LOC_W-1:0]         o_loc_reg, o_loc_next;
    logic [DATA_W-1:0]        o_min_reg, o_min_next;
    logic [DATA_W-1:0]        o_max_reg, o_max_next;
    logic [LOC_W-1:0]         o_count_reg, o_count_next;

    mem_req_t                 mreq;
    logic [DATA_W-1:0]        rd_data;
    cmp_t                     cmp;
    logic                     issue;
    logic [POS_W-1:0]         mid_sum;

    // entry memory and compare unit
    itsr_store u_store (
        .clk     (clk),
        .req     (mreq),
        .rd_data (rd_data)
    );

    itsr_cmp u_cmp (
        .data    (rd_data),
        .key     (value_reg),
        .min_val (min_reg),
        .max_val (max_reg),
        .flags   (cmp)
    );

    assign issue   = (rd_ptr_reg < count_reg);
    assign mid_sum = POS_W'(unsigned'(left_reg)) + POS_W'(unsigned'(right_reg));

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pv_reg        <= 1'b0;
            skip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pv_reg        <= pv_next;
            skip_reg      <= skip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and output payload
    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        value_reg    <= value_next;
        rd_ptr_reg   <= rd_ptr_next;
        wr_ptr_reg   <= wr_ptr_next;
        p_idx_reg    <= p_idx_next;
        mid_reg      <= mid_next;
        left_reg     <= left_next;
        right_reg    <= right_next;
        status_reg   <= status_next;
        loc_reg      <= loc_next;
        min_reg      <= min_next;
        max_reg      <= max_next;
        o_status_reg <= o_status_next;
        o_loc_reg    <= o_loc_next;
        o_min_reg    <= o_min_next;
        o_max_reg    <= o_max_next;
        o_count_reg  <= o_count_next;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        pv_next        = 1'b0;
        skip_next      = skip_reg;
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        value_next     = value_reg;
        p_idx_next     = p_idx_reg;
        mid_next       = mid_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        status_next    = status_reg;
        loc_next       = loc_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        o_status_next  = o_status_reg;
        o_loc_next     = o_loc_reg;
        o_min_next     = o_min_reg;
        o_max_next     = o_max_reg;
        o_count_next   = o_count_reg;
        mreq           = '0;

        // output register drains on its own
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next  = req.kind;
                    value_next = req.value;
                    state_next = S_START;
                end
            end

            S_START:
            begin
                status_next = STAT_OK;
                loc_next    = LOC_NONE;
                min_next    = '0;
                max_next    = '0;
                rd_ptr_next = '0;
                wr_ptr_next = '0;
                skip_next   = 1'b0;
                state_next  = S_DONE;
                unique case (kind_reg)
                    KIND_APPEND:
                    begin
                        if (count_reg >= CNT_W'(DEPTH))
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            mreq.wr_en   = 1'b1;
                            mreq.wr_addr = count_reg[IDX_W-1:0];
                            mreq.wr_data = value_reg;
                            loc_next     = LOC_W'(count_reg);
                            count_next   = count_reg + CNT_W'(1);
                        end
                    end
                    KIND_ZERO:
                    begin
                        state_next = S_ZERO;
                    end
                    KIND_FIND, KIND_REMOVE:
                    begin
                        status_next = STAT_NOT_FOUND;
                        state_next  = S_SCAN;
                    end
                    KIND_OFIND:
                    begin
                        status_next = STAT_NOT_FOUND;
                        left_next   = '0;
                        right_next  = POS_W'(count_reg) - POS_W'(1);
                        state_next  = S_BIN_RD;
                    end
                    KIND_MINMAX:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = STAT_EMPTY;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            // clear live entries one per cycle
            S_ZERO:
            begin
                if (issue)
                begin
                    mreq.wr_en   = 1'b1;
                    mreq.wr_addr = rd_ptr_reg[IDX_W-1:0];
                    mreq.wr_data = '0;
                    rd_ptr_next  = rd_ptr_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            // one read issued per cycle, the previous read processed
            S_SCAN:
            begin
                if (issue)
                begin
                    mreq.rd_en   = 1'b1;
                    mreq.rd_addr = rd_ptr_reg[IDX_W-1:0];
                    rd_ptr_next  = rd_ptr_reg + CNT_W'(1);
                    pv_next      = 1'b1;
                    p_idx_next   = rd_ptr_reg[IDX_W-1:0];
                end

                if (pv_reg)
                begin
                    case (kind_reg)
                        KIND_FIND:
                        begin
                            if (cmp.eq)
                            begin
                                status_next = STAT_OK;
                                loc_next    = LOC_W'(p_idx_reg);
                                pv_next     = 1'b0;
                                state_next  = S_DONE;
                            end
                        end
                        KIND_REMOVE:
                        begin
                            // the entry after a removed one slides in unchecked
                            if (cmp.eq && !skip_reg)
                            begin
                                status_next = STAT_OK;
                                loc_next    = LOC_W'(wr_ptr_reg);
                                skip_next   = 1'b1;
                            end
                            else
                            begin
                                mreq.wr_en   = 1'b1;
                                mreq.wr_addr = wr_ptr_reg[IDX_W-1:0];
                                mreq.wr_data = rd_data;
                                wr_ptr_next  = wr_ptr_reg + CNT_W'(1);
                                skip_next    = 1'b0;
                            end
                        end
                        default:
                        begin
                            if ((p_idx_reg == '0) || cmp.data_lt_min)
                            begin
                                min_next = rd_data;
                            end
                            if ((p_idx_reg == '0) || cmp.data_gt_max)
                            begin
                                max_next = rd_data;
                            end
                        end
                    endcase
                end
                else if (!issue)
                begin
                    if (kind_reg == KIND_REMOVE)
                    begin
                        count_next = wr_ptr_reg;
                    end
                    state_next = S_DONE;
                end
            end

            // probe the midpoint
            S_BIN_RD:
            begin
                if (left_reg > right_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    mid_next     = mid_sum[IDX_W:1];
                    mreq.rd_en   = 1'b1;
                    mreq.rd_addr = mid_sum[IDX_W:1];
                    state_next   = S_BIN_CMP;
                end
            end

            S_BIN_CMP:
            begin
                state_next = S_BIN_RD;
                if (cmp.eq)
                begin
                    status_next = STAT_OK;
                    loc_next    = LOC_W'(mid_reg);
                    state_next  = S_DONE;
                end
                else if (cmp.data_lt_key)
                begin
                    left_next = POS_W'(mid_reg) + POS_W'(1);
                end
                else
                begin
                    right_next = POS_W'(mid_reg) - POS_W'(1);
                end
            end

            // hand the result to the output register once it is free
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    o_status_next  = status_reg;
                    o_loc_next     = loc_reg;
                    o_min_next     = min_reg;
                    o_max_next     = max_reg;
                    o_count_next   = LOC_W'(count_reg);
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // channel outputs
    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = o_status_reg;
    assign rsp.location    = o_loc_reg;
    assign rsp.min_value   = o_min_reg;
    assign rsp.max_value   = o_max_reg;
    assign rsp.entry_count = o_count_reg;

    // live count stays within the table
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("live count above table depth");

    // one operation at a time
    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("beat accepted while an operation was in flight");

    // compaction write never passes the read pointer
    a_wr_behind: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (wr_ptr_reg <= rd_ptr_reg))
        else $error("remove write pointer ahead of read pointer");

    // no read and write of the same entry in one cycle
    a_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (mreq.rd_en && mreq.wr_en) |-> (mreq.rd_addr != mreq.wr_addr))
        else $error("memory read and write hit the same entry");

    // remove never grows the table
    a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && kind_reg == KIND_REMOVE) |=> (count_reg <= $past(count_reg)))
        else $error("remove increased the live count");

endmodule
